@@ rtl/xld_pkg.sv @@
// xld_pkg: types, codes and default sizes for the xor-linked deque
// no dependencies; compile first

package xld_pkg;

   localparam int XLD_POOL_DEPTH  = 16;
   localparam int XLD_VALUE_WIDTH = 32;

   localparam int REQ_VALUE_WIDTH = 32;
   localparam int RSP_VALUE_WIDTH = 32;
   localparam int RSP_COUNT_WIDTH = 5;

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

endpackage

@@ rtl/xld_if.sv @@
// xld_req_if, xld_rsp_if: valid/ready channels of the xor-linked deque
// depends on xld_pkg

interface xld_req_if import xld_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic                       operation;
   logic                       at_tail_end;
   logic [REQ_VALUE_WIDTH-1:0] push_value;

   modport source (output valid, output operation, output at_tail_end, output push_value,
                   input ready);
   modport sink   (input valid, input operation, input at_tail_end, input push_value,
                   output ready);
endinterface

interface xld_rsp_if import xld_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [RSP_VALUE_WIDTH-1:0] popped_value;
   logic [1:0]                 status;
   logic [RSP_COUNT_WIDTH-1:0] entry_count;

   modport source (output valid, output popped_value, output status, output entry_count,
                   input ready);
   modport sink   (input valid, input popped_value, input status, input entry_count,
                   output ready);
endinterface

@@ rtl/xld_node_ram.sv @@
// xld_node_ram: node pool storage (value and link) for interior list nodes
// one write port, two registered read ports with write bypass; uses xld_pkg

module xld_node_ram import xld_pkg::*; #(
   parameter int POOL_DEPTH  = XLD_POOL_DEPTH,
   parameter int VALUE_WIDTH = XLD_VALUE_WIDTH
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(POOL_DEPTH+1)-1:0]  wr_addr,
   input  logic [VALUE_WIDTH-1:0]           wr_val,
   input  logic [$clog2(POOL_DEPTH+1)-1:0]  wr_link,
   input  logic [$clog2(POOL_DEPTH+1)-1:0]  rd_a_addr,
   output logic [VALUE_WIDTH-1:0]           rd_a_val,
   output logic [$clog2(POOL_DEPTH+1)-1:0]  rd_a_link,
   input  logic [$clog2(POOL_DEPTH+1)-1:0]  rd_b_addr,
   output logic [VALUE_WIDTH-1:0]           rd_b_val,
   output logic [$clog2(POOL_DEPTH+1)-1:0]  rd_b_link
);

   localparam int AW = $clog2(POOL_DEPTH+1);
   localparam int WW = VALUE_WIDTH + AW;

   logic [WW-1:0] node_mem [POOL_DEPTH+1];
   logic [WW-1:0] wr_word;
   logic [WW-1:0] rd_a_ff;
   logic [WW-1:0] rd_b_ff;

   assign wr_word = {wr_val, wr_link};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         node_mem[wr_addr] <= wr_word;
      end
      rd_a_ff <= (wr_en && wr_addr == rd_a_addr) ? wr_word : node_mem[rd_a_addr];
      rd_b_ff <= (wr_en && wr_addr == rd_b_addr) ? wr_word : node_mem[rd_b_addr];
   end

   assign rd_a_val  = rd_a_ff[WW-1:AW];
   assign rd_a_link = rd_a_ff[AW-1:0];
   assign rd_b_val  = rd_b_ff[WW-1:AW];
   assign rd_b_link = rd_b_ff[AW-1:0];

endmodule

@@ rtl/xld_free_pool.sv @@
// xld_free_pool: node address allocator, a stack of released addresses
// over a counter of never used ones; uses xld_pkg

module xld_free_pool import xld_pkg::*; #(
   parameter int POOL_DEPTH = XLD_POOL_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             alloc,
   input  logic                             release_en,
   input  logic [$clog2(POOL_DEPTH+1)-1:0]  release_addr,
   output logic [$clog2(POOL_DEPTH+1)-1:0]  alloc_addr
);

   localparam int AW = $clog2(POOL_DEPTH+1);
   localparam int CW = $clog2(POOL_DEPTH+1);
   localparam int SW = $clog2(POOL_DEPTH);
   localparam int FW = $clog2(POOL_DEPTH+2);

   logic [AW-1:0] stack_mem [POOL_DEPTH];
   logic [CW-1:0] freed_ff;
   logic [CW-1:0] freed_in;
   logic [FW-1:0] fresh_ff;
   logic [FW-1:0] fresh_in;
   logic [AW-1:0] top_ff;
   logic [CW-1:0] rd_pos;
   logic [SW-1:0] rd_idx;
   logic [SW-1:0] wr_idx;

   always_comb begin
      freed_in = freed_ff;
      fresh_in = fresh_ff;
      if (release_en) begin
         freed_in = freed_ff + CW'(1);
      end else if (alloc) begin
         if (freed_ff != '0) begin
            freed_in = freed_ff - CW'(1);
         end else begin
            fresh_in = fresh_ff + FW'(1);
         end
      end
   end

   assign rd_pos     = freed_in - CW'(1);
   assign rd_idx     = rd_pos[SW-1:0];
   assign wr_idx     = freed_ff[SW-1:0];
   assign alloc_addr = (freed_ff != '0) ? top_ff : fresh_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         freed_ff <= '0;
         fresh_ff <= FW'(1);
      end else begin
         freed_ff <= freed_in;
         fresh_ff <= fresh_in;
      end
   end

   // top of stack prefetch
   always_ff @(posedge clock) begin
      if (release_en) begin
         stack_mem[wr_idx] <= release_addr;
      end
      top_ff <= (release_en && wr_idx == rd_idx) ? release_addr : stack_mem[rd_idx];
   end

endmodule

@@ rtl/xor_linked_deque.sv @@
// xor_linked_deque: double-ended queue kept as an xor-linked list in a node pool
// depends on xld_pkg, xld_if, xld_node_ram, xld_free_pool
//
//   channel   dir   transaction
//   req_bus   in    operation, at_tail_end, push_value
//   rsp_bus   out   popped_value, status, entry_count (one per req transaction)
//
// one transaction per cycle sustained while rsp is not stalled; req passes through
// the input register, then the result register, to rsp
// head and tail nodes live in registers; the node ram is read ahead at both
// end neighbors so no push or pop waits on a ram read
// synchronous reset, no clearing pass
// a stalled rsp holds the input register, then req ready drops

module xor_linked_deque import xld_pkg::*; #(
   parameter int POOL_DEPTH  = XLD_POOL_DEPTH,
   parameter int VALUE_WIDTH = XLD_VALUE_WIDTH
) (
   input logic       clock,
   input logic       reset,
   xld_req_if.sink   req_bus,
   xld_rsp_if.source rsp_bus
);

   localparam int AW = $clog2(POOL_DEPTH+1);
   localparam int CW = $clog2(POOL_DEPTH+1);
   localparam int VW = VALUE_WIDTH;

   logic                       op_valid_ff, op_valid_in;
   logic                       op_code_ff, op_code_in;
   logic                       op_tail_ff, op_tail_in;
   logic [VW-1:0]              op_val_ff, op_val_in;

   logic [AW-1:0]              head_addr_ff, head_addr_in;
   logic [VW-1:0]              head_val_ff, head_val_in;
   logic [AW-1:0]              head_link_ff, head_link_in;
   logic [AW-1:0]              tail_addr_ff, tail_addr_in;
   logic [VW-1:0]              tail_val_ff, tail_val_in;
   logic [AW-1:0]              tail_link_ff, tail_link_in;
   logic [CW-1:0]              held_ff, held_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [RSP_VALUE_WIDTH-1:0] popped_ff, popped_in;
   status_type                 status_ff, status_in;
   logic [RSP_COUNT_WIDTH-1:0] count_ff, count_in;

   logic                       exec;
   logic                       req_take;
   logic [VW+REQ_VALUE_WIDTH-1:0] push_ext;
   logic [VW-1:0]              pop_val;
   logic [VW+RSP_VALUE_WIDTH-1:0] pop_ext;
   logic [CW+RSP_COUNT_WIDTH-1:0] count_ext;
   logic                       is_empty, is_full, is_one, is_two;

   logic                       alloc, release_en;
   logic [AW-1:0]              release_addr, alloc_addr;
   logic                       wr_en;
   logic [AW-1:0]              wr_addr, wr_link;
   logic [VW-1:0]              wr_val;
   logic [VW-1:0]              hnb_val, tnb_val;
   logic [AW-1:0]              hnb_link, tnb_link;

   assign exec            = op_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready   = !op_valid_ff || exec;
   assign req_take        = req_bus.valid && req_bus.ready;
   assign push_ext        = {{VW{req_bus.push_value[REQ_VALUE_WIDTH-1]}}, req_bus.push_value};

   assign is_empty = held_ff == '0;
   assign is_full  = held_ff == CW'(POOL_DEPTH);
   assign is_one   = held_ff == CW'(1);
   assign is_two   = held_ff == CW'(2);

   always_comb begin
      op_valid_in = op_valid_ff;
      op_code_in  = op_code_ff;
      op_tail_in  = op_tail_ff;
      op_val_in   = op_val_ff;
      if (req_take) begin
         op_valid_in = 1'b1;
         op_code_in  = req_bus.operation;
         op_tail_in  = req_bus.at_tail_end;
         op_val_in   = push_ext[VW-1:0];
      end else if (exec) begin
         op_valid_in = 1'b0;
      end
   end

   always_comb begin
      head_addr_in = head_addr_ff;
      head_val_in  = head_val_ff;
      head_link_in = head_link_ff;
      tail_addr_in = tail_addr_ff;
      tail_val_in  = tail_val_ff;
      tail_link_in = tail_link_ff;
      held_in      = held_ff;
      status_in    = ST_OK;
      pop_val      = '0;
      alloc        = 1'b0;
      release_en   = 1'b0;
      release_addr = '0;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_val       = '0;
      wr_link      = '0;
      if (exec) begin
         if (op_code_ff == OP_PUSH) begin
            if (is_full) begin
               status_in = ST_FULL;
            end else begin
               alloc   = 1'b1;
               held_in = held_ff + CW'(1);
               if (is_empty) begin
                  head_addr_in = alloc_addr;
                  head_val_in  = op_val_ff;
                  head_link_in = '0;
                  tail_addr_in = alloc_addr;
                  tail_val_in  = op_val_ff;
                  tail_link_in = '0;
               end else if (op_tail_ff) begin
                  tail_addr_in = alloc_addr;
                  tail_val_in  = op_val_ff;
                  tail_link_in = tail_addr_ff;
                  if (is_one) begin
                     head_link_in = head_link_ff ^ alloc_addr;
                  end else begin
                     wr_en   = 1'b1;
                     wr_addr = tail_addr_ff;
                     wr_val  = tail_val_ff;
                     wr_link = tail_link_ff ^ alloc_addr;
                  end
               end else begin
                  head_addr_in = alloc_addr;
                  head_val_in  = op_val_ff;
                  head_link_in = head_addr_ff;
                  if (is_one) begin
                     tail_link_in = tail_link_ff ^ alloc_addr;
                  end else begin
                     wr_en   = 1'b1;
                     wr_addr = head_addr_ff;
                     wr_val  = head_val_ff;
                     wr_link = head_link_ff ^ alloc_addr;
                  end
               end
            end
         end else begin
            if (is_empty) begin
               status_in = ST_EMPTY;
            end else begin
               release_en = 1'b1;
               held_in    = held_ff - CW'(1);
               if (is_one) begin
                  pop_val      = op_tail_ff ? tail_val_ff : head_val_ff;
                  release_addr = op_tail_ff ? tail_addr_ff : head_addr_ff;
                  head_addr_in = '0;
                  head_link_in = '0;
                  tail_addr_in = '0;
                  tail_link_in = '0;
               end else if (op_tail_ff) begin
                  pop_val      = tail_val_ff;
                  release_addr = tail_addr_ff;
                  if (is_two) begin
                     tail_addr_in = head_addr_ff;
                     tail_val_in  = head_val_ff;
                     tail_link_in = head_link_ff ^ tail_addr_ff;
                     head_link_in = head_link_ff ^ tail_addr_ff;
                  end else begin
                     tail_addr_in = tail_link_ff;
                     tail_val_in  = tnb_val;
                     tail_link_in = tnb_link ^ tail_addr_ff;
                  end
               end else begin
                  pop_val      = head_val_ff;
                  release_addr = head_addr_ff;
                  if (is_two) begin
                     head_addr_in = tail_addr_ff;
                     head_val_in  = tail_val_ff;
                     head_link_in = tail_link_ff ^ head_addr_ff;
                     tail_link_in = tail_link_ff ^ head_addr_ff;
                  end else begin
                     head_addr_in = head_link_ff;
                     head_val_in  = hnb_val;
                     head_link_in = hnb_link ^ head_addr_ff;
                  end
               end
            end
         end
      end
   end

   assign pop_ext   = {{RSP_VALUE_WIDTH{pop_val[VW-1]}}, pop_val};
   assign count_ext = {{RSP_COUNT_WIDTH{1'b0}}, held_in};

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      popped_in    = popped_ff;
      count_in     = count_ff;
      if (exec) begin
         rsp_valid_in = 1'b1;
         popped_in    = pop_ext[RSP_VALUE_WIDTH-1:0];
         count_in     = count_ext[RSP_COUNT_WIDTH-1:0];
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         held_ff      <= '0;
         head_addr_ff <= '0;
         head_link_ff <= '0;
         tail_addr_ff <= '0;
         tail_link_ff <= '0;
      end else begin
         op_valid_ff  <= op_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         held_ff      <= held_in;
         head_addr_ff <= head_addr_in;
         head_link_ff <= head_link_in;
         tail_addr_ff <= tail_addr_in;
         tail_link_ff <= tail_link_in;
      end
   end

   always_ff @(posedge clock) begin
      op_code_ff  <= op_code_in;
      op_tail_ff  <= op_tail_in;
      op_val_ff   <= op_val_in;
      head_val_ff <= head_val_in;
      tail_val_ff <= tail_val_in;
      popped_ff   <= popped_in;
      count_ff    <= count_in;
      if (exec) begin
         status_ff <= status_in;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.popped_value = popped_ff;
   assign rsp_bus.status       = status_ff;
   assign rsp_bus.entry_count  = count_ff;

   xld_node_ram #(
      .POOL_DEPTH  (POOL_DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_node_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_val    (wr_val),
      .wr_link   (wr_link),
      .rd_a_addr (head_link_in),
      .rd_a_val  (hnb_val),
      .rd_a_link (hnb_link),
      .rd_b_addr (tail_link_in),
      .rd_b_val  (tnb_val),
      .rd_b_link (tnb_link)
   );

   xld_free_pool #(
      .POOL_DEPTH (POOL_DEPTH)
   ) u_free_pool (
      .clock        (clock),
      .reset        (reset),
      .alloc        (alloc),
      .release_en   (release_en),
      .release_addr (release_addr),
      .alloc_addr   (alloc_addr)
   );

endmodule

@@ rtl/xld_checker.sv @@
// xld_checker: port-level checks on the xor-linked deque result channel
// depends on xld_pkg; bound to xor_linked_deque below

module xld_checker import xld_pkg::*; #(
   parameter int POOL_DEPTH = XLD_POOL_DEPTH
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [RSP_VALUE_WIDTH-1:0] popped_value,
   input logic [1:0]                 status,
   input logic [RSP_COUNT_WIDTH-1:0] entry_count
);

   localparam logic [RSP_COUNT_WIDTH-1:0] FULL_COUNT = RSP_COUNT_WIDTH'(POOL_DEPTH);

   rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(popped_value) && $stable(status)
                                   && $stable(entry_count))
      else $error("rsp transaction changed while stalled");

   error_no_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status != ST_OK |-> popped_value == '0)
      else $error("failed operation returned a value");

   empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status == ST_EMPTY |-> entry_count == '0)
      else $error("pop from empty list with nonzero count");

   full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status == ST_FULL |-> entry_count == FULL_COUNT)
      else $error("push into full pool with count below pool depth");

endmodule

bind xor_linked_deque xld_checker #(
   .POOL_DEPTH (POOL_DEPTH)
) u_xld_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .popped_value (rsp_bus.popped_value),
   .status       (rsp_bus.status),
   .entry_count  (rsp_bus.entry_count)
);

@@ tb/tb_top.sv @@
// tb_top: self-checking bench for xor_linked_deque, with a deque predictor and
// a result checker; push/pop traffic is directed, then random, with idling and stalls
// depends on xld_pkg, xld_if and the xor_linked_deque rtl

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import xld_pkg::*;

   localparam int DEPTH     = XLD_POOL_DEPTH;
   localparam int AW        = 5;
   localparam int RUN_LIMIT = 400000;
   localparam int WAIT_MAX  = 12;

   typedef struct {
      logic [RSP_VALUE_WIDTH-1:0] popped;
      status_type                 status;
      logic [RSP_COUNT_WIDTH-1:0] count;
   } deque_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   xld_req_if req_bus ();
   xld_rsp_if rsp_bus ();

   xor_linked_deque dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predicted deque state
   logic [31:0]   node_val  [1:DEPTH];
   logic [AW-1:0] node_link [1:DEPTH];
   logic [AW-1:0] free_stack [0:DEPTH-1];
   logic [AW-1:0] head_addr;
   logic [AW-1:0] tail_addr;
   int            free_top;
   int            held;

   deque_result_type expected_results [$];
   int            error_count     = 0;
   int            cycle_count     = 0;
   bit            no_gaps         = 1'b0;
   int            rsp_hold_cycles = 0;

   function automatic void deque_clear();
      for (int i = 0; i < DEPTH; i++) begin
         free_stack[i] = AW'(DEPTH - i);
      end
      free_top  = DEPTH;
      held      = 0;
      head_addr = '0;
      tail_addr = '0;
   endfunction

   function automatic deque_result_type deque_apply(op_type op, logic at_tail,
                                                    logic [31:0] value);
      deque_result_type r;
      logic [AW-1:0] a;
      logic [AW-1:0] nb;
      r.popped = '0;
      r.status = ST_OK;
      if (op == OP_PUSH) begin
         if (free_top == 0) begin
            r.status = ST_FULL;
         end else begin
            free_top--;
            a = free_stack[free_top];
            node_val[a] = value;
            if (head_addr == '0) begin
               node_link[a] = '0;
               head_addr    = a;
               tail_addr    = a;
            end else if (at_tail) begin
               node_link[a]          = tail_addr;
               node_link[tail_addr] ^= a;
               tail_addr             = a;
            end else begin
               node_link[a]          = head_addr;
               node_link[head_addr] ^= a;
               head_addr             = a;
            end
            held++;
         end
      end else begin
         if (held == 0) begin
            r.status = ST_EMPTY;
         end else begin
            a        = at_tail ? tail_addr : head_addr;
            nb       = node_link[a];
            r.popped = node_val[a];
            if (nb != '0) node_link[nb] ^= a;
            if (at_tail) begin
               tail_addr = nb;
               if (nb == '0) head_addr = '0;
            end else begin
               head_addr = nb;
               if (nb == '0) tail_addr = '0;
            end
            free_stack[free_top] = a;
            free_top++;
            held--;
         end
      end
      r.count = RSP_COUNT_WIDTH'(held);
      return r;
   endfunction

   function automatic int draw_wait();
      if (no_gaps) return 0;
      return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, WAIT_MAX);
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return 32'h0000_0000;
         3: return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_op(op_type op, logic at_tail, logic [31:0] value);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid       <= 1'b1;
      req_bus.operation   <= op;
      req_bus.at_tail_end <= at_tail;
      req_bus.push_value  <= value;
      do @(posedge clock); while (!req_bus.ready);
      expected_results.push_back(deque_apply(op, at_tail, value));
   endtask

   task automatic test_empty_pops();
      send_op(OP_POP, 1'b0, $urandom);
      send_op(OP_POP, 1'b1, $urandom);
   endtask

   // single-node pops at both ends, then extremes at both ends
   task automatic test_end_extremes();
      send_op(OP_PUSH, 1'b0, 32'h7fff_ffff);
      send_op(OP_POP,  1'b1, $urandom);
      send_op(OP_PUSH, 1'b1, 32'h8000_0000);
      send_op(OP_POP,  1'b0, $urandom);
      send_op(OP_PUSH, 1'b0, 32'h0000_0000);
      send_op(OP_PUSH, 1'b1, 32'hffff_ffff);
      send_op(OP_PUSH, 1'b0, 32'h0000_0001);
      send_op(OP_POP,  1'b0, $urandom);
      send_op(OP_POP,  1'b1, $urandom);
   endtask

   task automatic test_full_pool();
      while (held < DEPTH) begin
         send_op(OP_PUSH, 1'($urandom_range(0, 1)), $urandom);
      end
      send_op(OP_PUSH, 1'b0, $urandom);
      send_op(OP_PUSH, 1'b1, $urandom);
   endtask

   task automatic test_random_walk(int count, int push_pct);
      op_type op;
      for (int i = 0; i < count; i++) begin
         op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
         send_op(op, 1'($urandom_range(0, 1)), pick_value());
      end
   endtask

   // receiver holds off while the sender streams, so req ready must drop
   task automatic test_rsp_backpressure();
      no_gaps         = 1'b1;
      rsp_hold_cycles = 60;
      test_random_walk(30, 60);
      no_gaps = 1'b0;
   endtask

   task automatic test_random_mix();
      int pct;
      for (int phase = 0; phase < 36; phase++) begin
         case (phase % 4)
            0: pct = 85;
            1: pct = 50;
            2: pct = 15;
            default: pct = $urandom_range(30, 70);
         endcase
         no_gaps = ($urandom_range(0, 3) == 0);
         test_random_walk(50, pct);
      end
      no_gaps = 1'b0;
   endtask

   initial begin
      req_bus.valid       = 1'b0;
      req_bus.operation   = OP_PUSH;
      req_bus.at_tail_end = 1'b0;
      req_bus.push_value  = '0;
      deque_clear();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_pops();
      test_end_extremes();
      test_full_pool();
      test_rsp_backpressure();
      test_random_mix();

      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

   initial begin
      int stall;
      rsp_bus.ready = 1'b0;
      do @(negedge clock); while (reset);
      forever begin
         if (rsp_hold_cycles > 0) begin
            stall           = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            stall = draw_wait();
         end
         if (stall > 0) begin
            @(negedge clock);
            rsp_bus.ready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   always @(posedge clock) begin
      deque_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected transaction, popped %h status %0d count %0d", $time,
                     rsp_bus.popped_value, rsp_bus.status, rsp_bus.entry_count);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_bus.popped_value !== want.popped) begin
               $display("%0t: popped_value expected %h actual %h", $time, want.popped,
                        rsp_bus.popped_value);
               error_count++;
            end
            if (rsp_bus.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status,
                        rsp_bus.status);
               error_count++;
            end
            if (rsp_bus.entry_count !== want.count) begin
               $display("%0t: entry_count expected %0d actual %0d", $time, want.count,
                        rsp_bus.entry_count);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= RUN_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

endmodule
